// File: hdl/atl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atl_pkg
// shared constants, kind codes and the mnemonic table for the token lexer
// ----------------------------------------------------------------------------
package atl_pkg;

    localparam int MAX_NAME_DEF     = 16;
    localparam int NUM_KEYWORDS_DEF = 53;
    localparam int TABLE_SIZE       = 53;
    localparam int KW_CHARS         = 11;

    localparam logic [2:0] KIND_NUMBER  = 3'd0;
    localparam logic [2:0] KIND_KEYWORD = 3'd1;
    localparam logic [2:0] KIND_LABEL   = 3'd2;
    localparam logic [2:0] KIND_LITERAL = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;
    localparam logic [2:0] KIND_BADCHAR = 3'd5;
    localparam logic [2:0] KIND_TOOLONG = 3'd6;

    localparam logic [30:0] NUM_MAX = 31'h7fff_ffff;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0a;

    // mnemonic text, padded with zeros
    function automatic logic [8*KW_CHARS-1:0] kw_text(input logic [5:0] i);
        logic [8*KW_CHARS-1:0] s;
        s = '0;
        unique case (i)
            6'd0:  s = "nop";      6'd1:  s = "push";     6'd2:  s = "add";
            6'd3:  s = "sub";      6'd4:  s = "mul";      6'd5:  s = "div";
            6'd6:  s = "addc";     6'd7:  s = "subc";     6'd8:  s = "inc";
            6'd9:  s = "dec";      6'd10: s = "swap";     6'd11: s = "xor";
            6'd12: s = "and";      6'd13: s = "or";       6'd14: s = "not";
            6'd15: s = "call";     6'd16: s = "pushpc";   6'd17: s = "jmp";
            6'd18: s = "ret";      6'd19: s = "ref";      6'd20: s = "dup";
            6'd21: s = "mod";      6'd22: s = "cmp";      6'd23: s = "jmpeq";
            6'd24: s = "jmplt";    6'd25: s = "jmpgt";    6'd26: s = "jmple";
            6'd27: s = "jmpge";    6'd28: s = "jmpab";    6'd29: s = "jmpbl";
            6'd30: s = "jmpae";    6'd31: s = "jmpbe";    6'd32: s = "jmpne";
            6'd33: s = "divmod";   6'd34: s = "addsp";    6'd35: s = "subsp";
            6'd36: s = "incsp";    6'd37: s = "decsp";    6'd38: s = "unref";
            6'd39: s = "pushbp";   6'd40: s = "popbp";    6'd41: s = "pushall";
            6'd42: s = "popall";   6'd43: s = "halt";     6'd44: s = "pushflags";
            6'd45: s = "popflags"; 6'd46: s = "refbp";    6'd47: s = "unrefbp";
            6'd48: s = "int";      6'd49: s = "out";      6'd50: s = "in";
            6'd51: s = "pushhwflags";                     6'd52: s = "_func";
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] kw_len(input logic [5:0] i);
        logic [8*KW_CHARS-1:0] s;
        logic [3:0] n;
        s = kw_text(i);
        n = '0;
        for (int k = 0; k < KW_CHARS; k++) begin
            if (s[8*k +: 8] != 8'd0) n = 4'(k + 1);
        end
        return n;
    endfunction

    // character at position p of mnemonic i (string packs first char at the top)
    function automatic logic [7:0] kw_char(input logic [5:0] i, input logic [3:0] p);
        logic [8*KW_CHARS-1:0] s;
        logic [3:0] n;
        logic [7:0] c;
        s = kw_text(i);
        n = kw_len(i);
        c = 8'd0;
        if (p < n) c = s[8*(n - 4'd1 - p) +: 8];
        return c;
    endfunction

endpackage
`default_nettype wire

// File: hdl/atl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// atl_ram
// generic single-port write, single-port registered read memory
// ----------------------------------------------------------------------------
module atl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hdl/assembler_token_lexer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// assembler_token_lexer_top
// character stream lexer: numbers, keywords, labels, literals
// ----------------------------------------------------------------------------
// One character per transfer. A character that extends or starts a token, or
// is skipped, is handled in ST_IDLE, and so is one that gives a single number
// or bad character result. A character that ends a word runs a sequencer over
// the name memory, which has a registered read. The keyword search visits each
// table entry in ST_SRCH and, on entries of the word's length, compares the
// name one character at a time through ST_CMP and ST_EMITW. A keyword or
// too-long result then follows, and label or literal names go out one
// character at a time, each read from the memory before ST_EMIT presents it.
// At end of input a flushed token is followed by the end result. The input is
// held off while a token's results are produced.
module assembler_token_lexer_top
    import atl_pkg::*;
#(
    parameter int MAX_NAME     = MAX_NAME_DEF,
    parameter int NUM_KEYWORDS = NUM_KEYWORDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_ch,
    input  wire logic        s_end_of_input,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_kind,
    output logic [5:0]       m_keyword_index,
    output logic [30:0]      m_number_value,
    output logic [7:0]       m_name_char,
    output logic             m_last
);
    localparam int AW = $clog2(MAX_NAME);
    localparam int LW = $clog2(MAX_NAME + 1);

    localparam logic [1:0] MODE_SKIP = 2'd0;
    localparam logic [1:0] MODE_NUM  = 2'd1;
    localparam logic [1:0] MODE_WORD = 2'd2;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SRCH   = 3'd1;
    localparam logic [2:0] ST_CMP    = 3'd2;
    localparam logic [2:0] ST_EMIT   = 3'd3;
    localparam logic [2:0] ST_EMITW  = 3'd4;
    localparam logic [2:0] ST_END    = 3'd5;

    logic [1:0]    mode_reg;
    logic [LW-1:0] len_reg;
    logic [30:0]   acc_reg;
    logic          ovf_reg;
    logic [2:0]    st_reg;
    logic [5:0]    kw_reg;
    logic [LW-1:0] pos_reg;
    logic          match_reg;
    logic [2:0]    ekind_reg;
    logic          eof_reg;

    // output register
    logic        ov_reg;
    logic [2:0]  ok_reg;
    logic [5:0]  oi_reg;
    logic [30:0] on_reg;
    logic [7:0]  oc_reg;
    logic        ol_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    rdata;

    atl_ram #(.WIDTH(8), .DEPTH(MAX_NAME)) u_name (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(s_ch),
        .raddr(raddr), .rdata(rdata)
    );

    logic out_free;
    assign out_free = !ov_reg || m_ready;
    assign s_ready  = (st_reg == ST_IDLE) && out_free;

    logic acc_in;
    assign acc_in = s_valid && s_ready;

    logic is_dig, is_let, is_sp;
    assign is_dig = s_ch >= 8'h30 && s_ch <= 8'h39;
    assign is_let = (s_ch >= 8'h61 && s_ch <= 8'h7a) || (s_ch >= 8'h41 && s_ch <= 8'h5a);
    assign is_sp  = s_ch == CH_SPACE || s_ch == CH_NL;

    logic [3:0] digit;
    assign digit = s_ch[3:0];

    // saturating acc*10+d, with acc*10 computed as shifts
    logic [35:0] prod;
    assign prod = ({5'd0, acc_reg} << 3) + ({5'd0, acc_reg} << 1) + {32'd0, digit};

    logic [AW-1:0] pos_a;
    assign pos_a = pos_reg[AW-1:0];

    always_comb begin
        we    = 1'b0;
        waddr = len_reg[AW-1:0];
        raddr = pos_a;
        if (acc_in && !s_end_of_input) begin
            if (mode_reg == MODE_SKIP && (is_let || s_ch == CH_UNDER)) begin
                we    = 1'b1;
                waddr = '0;
            end else if (mode_reg == MODE_WORD && (is_let || is_dig)
                         && len_reg < LW'(MAX_NAME)) begin
                we = 1'b1;
            end
        end
    end

    logic [LW-1:0] pos_inc;
    assign pos_inc = pos_reg + LW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_SKIP;
            len_reg   <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            st_reg    <= ST_IDLE;
            ov_reg    <= 1'b0;
            kw_reg    <= '0;
            pos_reg   <= '0;
            match_reg <= 1'b0;
            ekind_reg <= KIND_LITERAL;
            eof_reg   <= 1'b0;
        end else begin
            if (ov_reg && m_ready) ov_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE: begin
                    if (acc_in) begin
                        oi_reg <= '0; on_reg <= '0; oc_reg <= '0; ol_reg <= 1'b1;
                        if (s_end_of_input) begin
                            eof_reg <= 1'b1;
                            priority if (mode_reg == MODE_NUM) begin
                                ov_reg <= 1'b1; ok_reg <= KIND_NUMBER;
                                on_reg <= acc_reg; ol_reg <= 1'b0;
                                st_reg <= ST_END;
                            end else if (mode_reg == MODE_WORD) begin
                                ekind_reg <= KIND_LITERAL;
                                kw_reg <= '0; pos_reg <= '0; match_reg <= 1'b1;
                                st_reg <= ST_SRCH;
                            end else begin
                                ov_reg <= 1'b1; ok_reg <= KIND_END;
                            end
                            mode_reg <= MODE_SKIP;
                        end else begin
                            eof_reg <= 1'b0;
                            unique case (mode_reg)
                                MODE_NUM: begin
                                    if (is_dig) begin
                                        acc_reg <= (prod > {5'd0, NUM_MAX}) ? NUM_MAX
                                                                           : prod[30:0];
                                    end else begin
                                        ov_reg <= 1'b1; ok_reg <= KIND_NUMBER;
                                        on_reg <= acc_reg;
                                        mode_reg <= MODE_SKIP;
                                    end
                                end
                                MODE_WORD: begin
                                    if (s_ch == CH_COLON) begin
                                        ekind_reg <= KIND_LABEL;
                                        pos_reg <= '0; kw_reg <= 6'(TABLE_SIZE);
                                        st_reg <= ST_SRCH;
                                        mode_reg <= MODE_SKIP;
                                    end else if (is_let || is_dig) begin
                                        if (len_reg < LW'(MAX_NAME)) begin
                                            len_reg <= len_reg + LW'(1);
                                        end else begin
                                            ovf_reg <= 1'b1;
                                        end
                                    end else begin
                                        ekind_reg <= KIND_LITERAL;
                                        kw_reg <= '0; pos_reg <= '0; match_reg <= 1'b1;
                                        st_reg <= ST_SRCH;
                                        mode_reg <= MODE_SKIP;
                                    end
                                end
                                default: begin
                                    if (is_dig) begin
                                        mode_reg <= MODE_NUM;
                                        acc_reg <= {27'd0, digit};
                                    end else if (is_let || s_ch == CH_UNDER) begin
                                        mode_reg <= MODE_WORD;
                                        len_reg <= LW'(1);
                                        ovf_reg <= 1'b0;
                                    end else if (!is_sp) begin
                                        ov_reg <= 1'b1; ok_reg <= KIND_BADCHAR;
                                    end
                                end
                            endcase
                        end
                    end
                end
                // decide: overflow, name emission, skip an entry, or start a keyword compare
                ST_SRCH: begin
                    if (ovf_reg) begin
                        if (out_free) begin
                            ov_reg <= 1'b1; ok_reg <= KIND_TOOLONG;
                            oi_reg <= '0; on_reg <= '0; oc_reg <= '0;
                            ol_reg <= !eof_reg;
                            st_reg <= eof_reg ? ST_END : ST_IDLE;
                        end
                    end else if (7'(kw_reg) >= 7'(NUM_KEYWORDS)
                                 || 7'(kw_reg) >= 7'(TABLE_SIZE)) begin
                        // no keyword: stream the name from the memory
                        pos_reg   <= '0;
                        match_reg <= 1'b0;
                        st_reg    <= ST_EMIT;
                    end else if (4'(kw_len(kw_reg)) != 4'(len_reg)
                                 || len_reg > LW'(KW_CHARS)) begin
                        kw_reg <= kw_reg + 6'd1;
                    end else begin
                        pos_reg <= '0; match_reg <= 1'b1;
                        st_reg <= ST_CMP;
                    end
                end
                // raddr follows pos; wait here for the registered read
                ST_CMP: begin
                    st_reg <= ST_EMITW;
                end
                ST_EMITW: begin
                    // rdata holds name[pos]
                    if (rdata != kw_char(kw_reg, 4'(pos_reg))) begin
                        kw_reg <= kw_reg + 6'd1;
                        st_reg <= ST_SRCH;
                    end else if (pos_inc == len_reg) begin
                        if (out_free) begin
                            ov_reg <= 1'b1; ok_reg <= KIND_KEYWORD;
                            oi_reg <= kw_reg; on_reg <= '0; oc_reg <= '0;
                            ol_reg <= !eof_reg;
                            st_reg <= eof_reg ? ST_END : ST_IDLE;
                        end
                    end else begin
                        pos_reg <= pos_inc;
                        st_reg  <= ST_CMP;
                    end
                end
                // name emission: read at pos, present once the registered read returns
                ST_EMIT: begin
                    if (match_reg) begin
                        // rdata is name[pos]
                        if (out_free) begin
                            ov_reg <= 1'b1; ok_reg <= ekind_reg;
                            oi_reg <= '0; on_reg <= '0; oc_reg <= rdata;
                            ol_reg <= (pos_inc == len_reg) && !eof_reg;
                            match_reg <= 1'b0;
                            if (pos_inc == len_reg) begin
                                st_reg <= eof_reg ? ST_END : ST_IDLE;
                            end else begin
                                pos_reg <= pos_inc;
                            end
                        end
                    end else begin
                        match_reg <= 1'b1;
                    end
                end
                ST_END: begin
                    if (out_free) begin
                        ov_reg <= 1'b1; ok_reg <= KIND_END;
                        oi_reg <= '0; on_reg <= '0; oc_reg <= '0; ol_reg <= 1'b1;
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid         = ov_reg;
    assign m_kind          = ok_reg;
    assign m_keyword_index = oi_reg;
    assign m_number_value  = on_reg;
    assign m_name_char     = oc_reg;
    assign m_last          = ol_reg;
endmodule
`default_nettype wire
